// File: hdl/artr_pkg.sv
package artr_pkg;

  // Table size and derived widths
  localparam int ENTRY_COUNT = 16;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int HDR_W   = 16;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int STATE_W = 2;
  localparam int LIFE_W  = 6;
  localparam int CFG_IDX_W = 1;

  // Protocol constants
  localparam int PROBE_GAP_SECS = 3;
  localparam int REACH_SECS     = 60;
  localparam int PROBE_SECS     = 60;

  localparam logic [LIFE_W-1:0] PROBE_LIFE = LIFE_W'(PROBE_SECS);
  localparam logic [LIFE_W-1:0] REACH_LIFE = LIFE_W'(REACH_SECS);

  localparam logic [HDR_W-1:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [HDR_W-1:0] ARP_PROTO_IP4 = 16'h0800;
  localparam logic [HDR_W-1:0] ARP_OP_REPLY  = 16'h0002;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REPLY  = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ANSWER  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABSENT  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

  // Neighbour states
  localparam logic [STATE_W-1:0] NB_PROBE   = 2'd0;
  localparam logic [STATE_W-1:0] NB_REACH   = 2'd1;
  localparam logic [STATE_W-1:0] NB_REPROBE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b1;

  // Lifetimes at which a probe request goes out
  function automatic logic [(1 << LIFE_W)-1:0] interval_mask();
    logic [(1 << LIFE_W)-1:0] m;
    m = '0;
    for (int i = 0; i < (1 << LIFE_W); i++) begin
      m[i] = ((i % PROBE_GAP_SECS) == 0);
    end
    return m;
  endfunction

  localparam logic [(1 << LIFE_W)-1:0] HIT_MASK = interval_mask();

  typedef struct packed {
    logic [IP_W-1:0]    gw;
    logic [MAC_W-1:0]   hw;
    logic [STATE_W-1:0] st;
    logic [LIFE_W-1:0]  life;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STAT_W-1:0]  status;
    logic [IP_W-1:0]    request_ip;
    logic [MAC_W-1:0]   learned_hw;
    logic [STATE_W-1:0] entry_state;
    logic               entry_valid;
    logic               last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // word taken this cycle
    logic scan_rd;  // read at scan index and advance
    logic answer;   // emit query answer from read data
    logic finish;   // emit closing done word of a scan
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

// File: hdl/artr_ram.sv
module artr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/artr_ctrl.sv
module artr_ctrl import artr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CMD_W-1:0] command_i,
  input  dp_status_t       status_i,
  output dp_ctrl_t         ctrl_o,
  output logic             busy_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_QANS  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.accept = 1'b1;
          case (command_i) inside
            CMD_QUERY:           state_d = ST_QANS;
            CMD_TICK, CMD_REPLY: state_d = ST_SCAN;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_QANS: begin
        ctrl_o.answer = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_SCAN: begin
        ctrl_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        ctrl_o.finish = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: hdl/artr_dpath.sv
module artr_dpath import artr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_ctrl_t             ctrl_i,
  output dp_status_t           status_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MAC_W-1:0]     cfg_wdata_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [IP_W-1:0]      gateway_addr_i,
  input  logic [HDR_W-1:0]     ether_type_i,
  input  logic [HDR_W-1:0]     arp_proto_i,
  input  logic [HDR_W-1:0]     arp_opcode_i,
  input  logic [MAC_W-1:0]     sender_hw_i,
  input  logic [IP_W-1:0]      sender_ip_i,
  input  logic [MAC_W-1:0]     target_hw_i,
  input  logic [IP_W-1:0]      target_ip_i,
  output logic                 res_strobe_o,
  output res_t                 res_o
);

  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;

  logic [ENTRY_COUNT-1:0] vld_q, vld_d;

  logic [CMD_W-1:0] op_q;
  logic             ok_q;
  logic [IP_W-1:0]  sip_q;
  logic [MAC_W-1:0] shw_q;
  logic             qok_q;
  logic [IDX_W-1:0] qaddr_q;

  logic [IDX_W-1:0] scan_idx_q, proc_idx_q;
  logic             pend_q;

  logic             res_strobe_q, res_strobe_d;
  res_t             res_q, res_d;

  logic [IDX_W-1:0] slot_addr;
  logic             in_range, slot_vld, reply_ok;

  entry_t           rd_entry, upd_entry, wr_entry;
  logic             upd_we, req_hit, ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [LIFE_W-1:0] life, life_sat;

  assign slot_addr = IDX_W'(slot_i);
  assign in_range  = (32'(slot_i) < 32'(ENTRY_COUNT));
  assign slot_vld  = in_range && vld_q[slot_addr];

  assign reply_ok = (ether_type_i == ETH_TYPE_ARP) && (arp_proto_i == ARP_PROTO_IP4) &&
                    (arp_opcode_i == ARP_OP_REPLY) && (target_hw_i == own_mac_q) &&
                    (target_ip_i == own_ip_q);

  assign status_o.scan_last = (scan_idx_q == IDX_W'(ENTRY_COUNT - 1));

  // Per-entry update of a tick or reply visit
  assign life     = rd_entry.life;
  assign life_sat = (life == '0) ? '0 : life - LIFE_W'(1);

  always_comb begin
    upd_entry = rd_entry;
    upd_we    = 1'b0;
    req_hit   = 1'b0;
    if (pend_q && vld_q[proc_idx_q]) begin
      if (op_q == CMD_TICK) begin
        case (rd_entry.st)
          NB_PROBE: begin
            req_hit        = HIT_MASK[life];
            upd_entry.life = (life == '0) ? PROBE_LIFE : life - LIFE_W'(1);
            upd_we         = 1'b1;
          end
          NB_REACH: begin
            upd_entry.life = life_sat;
            if (life_sat == '0) begin
              upd_entry.st = NB_REPROBE;
            end
            upd_we = 1'b1;
          end
          NB_REPROBE: begin
            req_hit        = HIT_MASK[life];
            upd_entry.life = life_sat;
            if (life_sat == '0) begin
              upd_entry.st = NB_PROBE;
            end
            upd_we = 1'b1;
          end
          default: ;
        endcase
      end else if (op_q == CMD_REPLY && ok_q && rd_entry.gw == sip_q &&
                   (rd_entry.st == NB_PROBE || rd_entry.st == NB_REPROBE)) begin
        upd_entry.hw   = shw_q;
        upd_entry.st   = NB_REACH;
        upd_entry.life = REACH_LIFE;
        upd_we         = 1'b1;
      end
    end
  end

  // Memory port selection: add writes at accept, scans write behind the read
  always_comb begin
    ram_we    = upd_we;
    ram_waddr = proc_idx_q;
    wr_entry  = upd_entry;
    if (ctrl_i.accept && command_i == CMD_ADD && in_range && !vld_q[slot_addr]) begin
      ram_we    = 1'b1;
      ram_waddr = slot_addr;
      wr_entry  = '{gw: gateway_addr_i, hw: '0, st: NB_PROBE, life: PROBE_LIFE};
    end
    ram_raddr = ctrl_i.accept ? slot_addr : scan_idx_q;
  end

  artr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  // Valid marks and result word
  always_comb begin
    vld_d        = vld_q;
    res_strobe_d = 1'b0;
    res_d        = '0;
    if (ctrl_i.accept) begin
      res_d.kind = KIND_DONE;
      res_d.last = 1'b1;
      case (command_i) inside
        CMD_ADD: begin
          res_strobe_d = 1'b1;
          if (!in_range) begin
            res_d.status = STAT_ABSENT;
          end else if (vld_q[slot_addr]) begin
            res_d.status = STAT_PRESENT;
          end else begin
            vld_d[slot_addr] = 1'b1;
          end
        end
        CMD_REMOVE: begin
          res_strobe_d = 1'b1;
          if (!slot_vld) begin
            res_d.status = STAT_ABSENT;
          end else begin
            vld_d[slot_addr] = 1'b0;
          end
        end
        CMD_QUERY, CMD_TICK, CMD_REPLY: ;
        default: res_strobe_d = 1'b1;
      endcase
    end else if (req_hit) begin
      res_strobe_d     = 1'b1;
      res_d.kind       = KIND_REQUEST;
      res_d.request_ip = rd_entry.gw;
    end else if (ctrl_i.answer) begin
      res_strobe_d = 1'b1;
      res_d.kind   = KIND_ANSWER;
      res_d.last   = 1'b1;
      if (qok_q && vld_q[qaddr_q]) begin
        res_d.request_ip  = rd_entry.gw;
        res_d.learned_hw  = rd_entry.hw;
        res_d.entry_state = rd_entry.st;
        res_d.entry_valid = 1'b1;
      end else begin
        res_d.status = STAT_ABSENT;
      end
    end else if (ctrl_i.finish) begin
      res_strobe_d = 1'b1;
      res_d.kind   = KIND_DONE;
      res_d.last   = 1'b1;
      res_d.status = (op_q == CMD_REPLY && !ok_q) ? STAT_IGNORED : STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q     <= '0;
      own_mac_q    <= '0;
      vld_q        <= '0;
      scan_idx_q   <= '0;
      pend_q       <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OWN_IP:  own_ip_q  <= cfg_wdata_i[IP_W-1:0];
          CFG_OWN_MAC: own_mac_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      vld_q        <= vld_d;
      res_strobe_q <= res_strobe_d;
      pend_q       <= ctrl_i.scan_rd;
      if (ctrl_i.accept) begin
        scan_idx_q <= '0;
      end else if (ctrl_i.scan_rd) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
    end
  end

  // Payload: hold captured fields of the current word
  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    proc_idx_q <= scan_idx_q;
    if (ctrl_i.accept) begin
      op_q    <= command_i;
      ok_q    <= reply_ok;
      sip_q   <= sender_ip_i;
      shw_q   <= sender_hw_i;
      qok_q   <= in_range;
      qaddr_q <= slot_addr;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

// File: hdl/arp_gateway_reachability_tracker_top.sv
// Channel    Direction  Handshake                    Payload
// command    in         start_i high, busy_o low     command_i .. target_ip_i
// result     out        res_strobe_o, one cycle      kind_o .. last_o
// config     in         cfg_we_i, no wait            cfg_idx_i, cfg_wdata_i
//
// Add, remove and unknown commands are decided at accept; the done word follows
// on the next cycle and busy_o stays low. Query reads the entry through
// the registered read of the entry memory, then registers the answer.
// Tick and reply do one memory read per entry, then drain the last read
// in a drain state, then give the closing done word.
// Reset clears the valid marks and the own address registers at once; no
// clearing pass. The receiver cannot stall: each word shows for one cycle.
module arp_gateway_reachability_tracker_top import artr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [IP_W-1:0]      gateway_addr_i,
  input  logic [HDR_W-1:0]     ether_type_i,
  input  logic [HDR_W-1:0]     arp_proto_i,
  input  logic [HDR_W-1:0]     arp_opcode_i,
  input  logic [MAC_W-1:0]     sender_hw_i,
  input  logic [IP_W-1:0]      sender_ip_i,
  input  logic [MAC_W-1:0]     target_hw_i,
  input  logic [IP_W-1:0]      target_ip_i,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MAC_W-1:0]     cfg_wdata_i,
  // result channel
  output logic                 res_strobe_o,
  output logic [KIND_W-1:0]    kind_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [IP_W-1:0]      request_ip_o,
  output logic [MAC_W-1:0]     learned_hw_o,
  output logic [STATE_W-1:0]   entry_state_o,
  output logic                 entry_valid_o,
  output logic                 last_o
);

  dp_ctrl_t   ctrl;
  dp_status_t dp_status;
  res_t       res;

  // Sequence commands: decode at accept, then walk the table for tick/reply
  artr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .status_i  (dp_status),
    .ctrl_o    (ctrl),
    .busy_o    (busy_o)
  );

  // Hold the table, own addresses and the result register
  artr_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (dp_status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .slot_i         (slot_i),
    .gateway_addr_i (gateway_addr_i),
    .ether_type_i   (ether_type_i),
    .arp_proto_i    (arp_proto_i),
    .arp_opcode_i   (arp_opcode_i),
    .sender_hw_i    (sender_hw_i),
    .sender_ip_i    (sender_ip_i),
    .target_hw_i    (target_hw_i),
    .target_ip_i    (target_ip_i),
    .res_strobe_o   (res_strobe_o),
    .res_o          (res)
  );

  // Unpack the result word onto its ports
  assign kind_o        = res.kind;
  assign status_o      = res.status;
  assign request_ip_o  = res.request_ip;
  assign learned_hw_o  = res.learned_hw;
  assign entry_state_o = res.entry_state;
  assign entry_valid_o = res.entry_valid;
  assign last_o        = res.last;

endmodule

// File: hdl/artr_checker.sv
module artr_checker import artr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                res_strobe_o,
  input logic [KIND_W-1:0]   kind_o,
  input logic [STAT_W-1:0]   status_o,
  input logic                entry_valid_o,
  input logic                last_o
);

  // An accepted word either answers at once or holds the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> res_strobe_o || busy_o)
    else $error("accepted word neither answered nor started work");

  a_request_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && kind_o == KIND_REQUEST |-> !last_o && busy_o)
    else $error("request word marked last or outside a scan");

  a_other_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && kind_o != KIND_REQUEST |-> last_o)
    else $error("answer or done word not marked last");

  a_busy_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_strobe_o && last_o)
    else $error("busy dropped without a closing word");

  a_answer_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && kind_o == KIND_ANSWER |-> entry_valid_o == (status_o == STAT_OK))
    else $error("query answer valid flag disagrees with status");

endmodule

bind arp_gateway_reachability_tracker_top artr_checker u_artr_checker (.*);
